// ===== rtl/tpcm_pkg.sv =====
// tpcm_pkg: shared types and constants for the touch point calibrated mapper
// no dependencies
package tpcm_pkg;

   localparam int RAW_W  = 12;
   localparam int NUM_W  = 11;
   localparam int DEN_W  = 13;
   localparam int OFF_W  = 16;
   localparam int DVD_W  = 22;   // magnitude of raw * num always fits here
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int SX_W   = 9;
   localparam int SY_W   = 8;
   localparam logic [3:0] COUNT_MASK = 4'h0F;
   localparam logic [3:0] MAX_POINTS = 4'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAL_VALID   = 4'd0,
      REG_AXIS_SWAP   = 4'd1,
      REG_X_SCALE_NUM = 4'd2,
      REG_X_SCALE_DEN = 4'd3,
      REG_X_OFFSET    = 4'd4,
      REG_Y_SCALE_NUM = 4'd5,
      REG_Y_SCALE_DEN = 4'd6,
      REG_Y_OFFSET    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic                    qneg;
      logic                    zero;
      logic signed [OFF_W-1:0] off;
   } axis_ctl_type;

   typedef struct packed {
      logic             touched;
      logic [RAW_W-1:0] raw_x;
      logic [RAW_W-1:0] raw_y;
   } meta_type;

   typedef struct packed {
      meta_type     meta;
      axis_ctl_type ctl;
   } x_payload_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
      logic signed [OFF_W-1:0] off;
   } axis_cfg_type;

endpackage

// ===== rtl/tpcm_front.sv =====
// tpcm_front: decodes the status read, picks axes, multiplies and takes magnitudes
// depends on tpcm_pkg
module tpcm_front
   import tpcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [7:0]          status_byte,
   input  logic [7:0]          x_high_byte,
   input  logic [7:0]          x_low_byte,
   input  logic [7:0]          y_high_byte,
   input  logic [7:0]          y_low_byte,
   input  logic                cal_valid,
   input  logic                axis_swap,
   input  axis_cfg_type        x_cfg,
   input  axis_cfg_type        y_cfg,
   output logic                out_valid,
   output logic [DVD_W-1:0]    x_dividend,
   output logic [DEN_W-1:0]    x_divisor,
   output x_payload_type       x_payload,
   output logic [DVD_W-1:0]    y_dividend,
   output logic [DEN_W-1:0]    y_divisor,
   output axis_ctl_type        y_payload
);

   logic valid_ff;
   logic [DVD_W-1:0] x_dvd_ff, x_dvd_in, y_dvd_ff, y_dvd_in;
   logic [DEN_W-1:0] x_div_ff, x_div_in, y_div_ff, y_div_in;
   x_payload_type x_pl_ff, x_pl_in;
   axis_ctl_type  y_pl_ff, y_pl_in;

   logic [3:0] count;
   logic [RAW_W-1:0] rx, ry, ax, ay;
   axis_cfg_type xc, yc;
   logic signed [23:0] x_prod, y_prod;
   logic signed [23:0] x_mag, y_mag;

   always_comb begin
      count = status_byte[3:0] & COUNT_MASK;
      rx = {x_high_byte[3:0], x_low_byte};
      ry = {y_high_byte[3:0], y_low_byte};
      if (cal_valid) begin
         ax = axis_swap ? ry : rx;
         ay = axis_swap ? rx : ry;
         xc = x_cfg;
         yc = y_cfg;
      end else begin
         // identity mapping with the axes crossed
         ax = ry;
         ay = rx;
         xc = '{num: NUM_W'(1), den: DEN_W'(1), off: '0};
         yc = '{num: NUM_W'(1), den: DEN_W'(1), off: '0};
      end
      x_prod = $signed({1'b0, ax}) * xc.num;
      y_prod = $signed({1'b0, ay}) * yc.num;
      x_mag  = x_prod[23] ? -x_prod : x_prod;
      y_mag  = y_prod[23] ? -y_prod : y_prod;
      x_dvd_in = x_mag[DVD_W-1:0];
      y_dvd_in = y_mag[DVD_W-1:0];
      x_div_in = xc.den[DEN_W-1] ? (~xc.den + DEN_W'(1)) : xc.den;
      y_div_in = yc.den[DEN_W-1] ? (~yc.den + DEN_W'(1)) : yc.den;
      x_pl_in.meta.touched = (count != 4'd0) && (count <= MAX_POINTS);
      x_pl_in.meta.raw_x   = rx;
      x_pl_in.meta.raw_y   = ry;
      x_pl_in.ctl.qneg     = x_prod[23] ^ xc.den[DEN_W-1];
      x_pl_in.ctl.zero     = (xc.den == '0);
      x_pl_in.ctl.off      = xc.off;
      y_pl_in.qneg         = y_prod[23] ^ yc.den[DEN_W-1];
      y_pl_in.zero         = (yc.den == '0);
      y_pl_in.off          = yc.off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         x_dvd_ff <= x_dvd_in;
         y_dvd_ff <= y_dvd_in;
         x_div_ff <= x_div_in;
         y_div_ff <= y_div_in;
         x_pl_ff  <= x_pl_in;
         y_pl_ff  <= y_pl_in;
      end
   end

   assign out_valid  = valid_ff;
   assign x_dividend = x_dvd_ff;
   assign x_divisor  = x_div_ff;
   assign x_payload  = x_pl_ff;
   assign y_dividend = y_dvd_ff;
   assign y_divisor  = y_div_ff;
   assign y_payload  = y_pl_ff;

endmodule

// ===== rtl/tpcm_div.sv =====
// tpcm_div: unsigned restoring divider, one quotient bit per pipeline stage
// depends on tpcm_pkg; carries an opaque payload alongside
module tpcm_div
   import tpcm_pkg::*;
#(
   parameter int PAYLOAD_W = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [DVD_W-1:0]     in_dividend,
   input  logic [DEN_W-1:0]     in_divisor,
   input  logic [PAYLOAD_W-1:0] in_payload,
   output logic                 out_valid,
   output logic [DVD_W-1:0]     out_quotient,
   output logic [PAYLOAD_W-1:0] out_payload
);

   logic                 valid_ff [DVD_W+1];
   logic [DEN_W-1:0]     rem_ff   [DVD_W+1];
   logic [DVD_W-1:0]     dvd_ff   [DVD_W+1];
   logic [DVD_W-1:0]     quo_ff   [DVD_W+1];
   logic [DEN_W-1:0]     div_ff   [DVD_W+1];
   logic [PAYLOAD_W-1:0] pl_ff    [DVD_W+1];

   // entry 0 is the input, not a register
   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = '0;
   assign dvd_ff[0]   = in_dividend;
   assign quo_ff[0]   = '0;
   assign div_ff[0]   = in_divisor;
   assign pl_ff[0]    = in_payload;

   for (genvar k = 0; k < DVD_W; k++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic             fits;
      logic [DEN_W-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k], dvd_ff[k][DVD_W-1]};
         fits   = trial >= {1'b0, div_ff[k]};
         rem_in = fits ? DEN_W'(trial - {1'b0, div_ff[k]}) : trial[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (enable) begin
            rem_ff[k+1] <= rem_in;
            dvd_ff[k+1] <= {dvd_ff[k][DVD_W-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][DVD_W-2:0], fits};
            div_ff[k+1] <= div_ff[k];
            pl_ff[k+1]  <= pl_ff[k];
         end
      end
   end

   assign out_valid    = valid_ff[DVD_W];
   assign out_quotient = quo_ff[DVD_W];
   assign out_payload  = pl_ff[DVD_W];

endmodule

// ===== rtl/tpcm_back.sv =====
// tpcm_back: restores quotient sign, adds offset, clamps, holds the result register
// depends on tpcm_pkg
module tpcm_back
   import tpcm_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [DVD_W-1:0] x_quotient,
   input  x_payload_type    x_payload,
   input  logic [DVD_W-1:0] y_quotient,
   input  axis_ctl_type     y_payload,
   output logic             out_valid,
   output logic             touched,
   output logic [SX_W-1:0]  screen_x,
   output logic [SY_W-1:0]  screen_y,
   output logic [RAW_W-1:0] raw_x,
   output logic [RAW_W-1:0] raw_y
);

   localparam logic signed [24:0] X_MAX = 25'(SCREEN_WIDTH - 1);
   localparam logic signed [24:0] Y_MAX = 25'(SCREEN_HEIGHT - 1);

   function automatic logic signed [24:0] map_value(
      input logic [DVD_W-1:0] q, input axis_ctl_type c);
      logic signed [24:0] qs;
      qs = $signed({3'b000, q});
      if (c.zero) begin
         qs = '0;
      end else if (c.qneg) begin
         qs = -qs;
      end
      return qs + 25'(c.off);
   endfunction

   function automatic logic signed [24:0] clamp(
      input logic signed [24:0] v, input logic signed [24:0] top);
      if (v < 0) begin
         return '0;
      end else if (v > top) begin
         return top;
      end
      return v;
   endfunction

   logic valid_ff, touched_ff, touched_in;
   logic [SX_W-1:0] sx_ff, sx_in;
   logic [SY_W-1:0] sy_ff, sy_in;
   logic [RAW_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [24:0] cx, cy;

   always_comb begin
      cx = clamp(map_value(x_quotient, x_payload.ctl), X_MAX);
      cy = clamp(map_value(y_quotient, y_payload), Y_MAX);
      touched_in = x_payload.meta.touched;
      // no touch reports every field as zero
      sx_in = touched_in ? cx[SX_W-1:0] : '0;
      sy_in = touched_in ? cy[SY_W-1:0] : '0;
      rx_in = touched_in ? x_payload.meta.raw_x : '0;
      ry_in = touched_in ? x_payload.meta.raw_y : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         touched_ff <= touched_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
   end

   assign out_valid = valid_ff;
   assign touched   = touched_ff;
   assign screen_x  = sx_ff;
   assign screen_y  = sy_ff;
   assign raw_x     = rx_ff;
   assign raw_y     = ry_ff;

endmodule

// ===== rtl/touch_point_calibrated_mapper_unit.sv =====
// touch point mapper: 1 multiply stage, 22 divider stages, 1 output stage
// throughput one item per cycle when not stalled; the 22 stage restoring divider sets the latency
// all stages advance together and stall only while a result waits at the output
// synchronous reset clears valid bits and loads calibration register defaults
// depends on tpcm_pkg, tpcm_front, tpcm_div, tpcm_back
module touch_point_calibrated_mapper_unit
   import tpcm_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_status_byte,
   input  logic [7:0]            req_x_high_byte,
   input  logic [7:0]            req_x_low_byte,
   input  logic [7:0]            req_y_high_byte,
   input  logic [7:0]            req_y_low_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_touched,
   output logic [SX_W-1:0]       rsp_screen_x,
   output logic [SY_W-1:0]       rsp_screen_y,
   output logic [RAW_W-1:0]      rsp_raw_x,
   output logic [RAW_W-1:0]      rsp_raw_y,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic cal_valid_ff, axis_swap_ff;
   axis_cfg_type x_cfg_ff, y_cfg_ff;
   logic enable;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_valid_ff <= 1'b0;
         axis_swap_ff <= 1'b0;
         x_cfg_ff     <= '{num: NUM_W'(1), den: DEN_W'(1), off: '0};
         y_cfg_ff     <= '{num: NUM_W'(1), den: DEN_W'(1), off: '0};
      end else if (csr_valid) begin
         case (csr_index)
            REG_CAL_VALID:   cal_valid_ff <= csr_data[0];
            REG_AXIS_SWAP:   axis_swap_ff <= csr_data[0];
            REG_X_SCALE_NUM: x_cfg_ff.num <= csr_data[NUM_W-1:0];
            REG_X_SCALE_DEN: x_cfg_ff.den <= csr_data[DEN_W-1:0];
            REG_X_OFFSET:    x_cfg_ff.off <= csr_data;
            REG_Y_SCALE_NUM: y_cfg_ff.num <= csr_data[NUM_W-1:0];
            REG_Y_SCALE_DEN: y_cfg_ff.den <= csr_data[DEN_W-1:0];
            REG_Y_OFFSET:    y_cfg_ff.off <= csr_data;
            default: ;
         endcase
      end
   end

   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   logic             f_valid;
   logic [DVD_W-1:0] f_x_dvd, f_y_dvd;
   logic [DEN_W-1:0] f_x_div, f_y_div;
   x_payload_type    f_x_pl, d_x_pl;
   axis_ctl_type     f_y_pl, d_y_pl;
   logic             d_x_valid, d_y_valid;
   logic [DVD_W-1:0] d_x_q, d_y_q;

   tpcm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (req_valid),
      .status_byte (req_status_byte),
      .x_high_byte (req_x_high_byte),
      .x_low_byte  (req_x_low_byte),
      .y_high_byte (req_y_high_byte),
      .y_low_byte  (req_y_low_byte),
      .cal_valid   (cal_valid_ff),
      .axis_swap   (axis_swap_ff),
      .x_cfg       (x_cfg_ff),
      .y_cfg       (y_cfg_ff),
      .out_valid   (f_valid),
      .x_dividend  (f_x_dvd),
      .x_divisor   (f_x_div),
      .x_payload   (f_x_pl),
      .y_dividend  (f_y_dvd),
      .y_divisor   (f_y_div),
      .y_payload   (f_y_pl)
   );

   tpcm_div #(.PAYLOAD_W($bits(x_payload_type))) u_div_x (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (f_valid),
      .in_dividend  (f_x_dvd),
      .in_divisor   (f_x_div),
      .in_payload   (f_x_pl),
      .out_valid    (d_x_valid),
      .out_quotient (d_x_q),
      .out_payload  (d_x_pl)
   );

   tpcm_div #(.PAYLOAD_W($bits(axis_ctl_type))) u_div_y (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (f_valid),
      .in_dividend  (f_y_dvd),
      .in_divisor   (f_y_div),
      .in_payload   (f_y_pl),
      .out_valid    (d_y_valid),
      .out_quotient (d_y_q),
      .out_payload  (d_y_pl)
   );

   tpcm_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (d_x_valid && d_y_valid),
      .x_quotient (d_x_q),
      .x_payload  (d_x_pl),
      .y_quotient (d_y_q),
      .y_payload  (d_y_pl),
      .out_valid  (rsp_valid),
      .touched    (rsp_touched),
      .screen_x   (rsp_screen_x),
      .screen_y   (rsp_screen_y),
      .raw_x      (rsp_raw_x),
      .raw_y      (rsp_raw_y)
   );

endmodule

// ===== rtl/tpcm_checker.sv =====
// tpcm_checker: port level checks for the touch point mapper, bound to the top level
// depends on tpcm_pkg
module tpcm_checker
   import tpcm_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_touched,
   input logic [SX_W-1:0]  rsp_screen_x,
   input logic [SY_W-1:0]  rsp_screen_y,
   input logic [RAW_W-1:0] rsp_raw_x,
   input logic [RAW_W-1:0] rsp_raw_y
);

   // a no touch item carries only zeros
   a_no_touch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_touched |-> rsp_screen_x == '0 && rsp_screen_y == '0
         && rsp_raw_x == '0 && rsp_raw_y == '0)
      else $error("no touch item with nonzero fields");

   // input side stalls exactly while a result is held
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not track output stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y))
      else $error("stalled item changed");

   // only checked when the screen fits the field width
   a_in_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_touched
         |-> (SCREEN_WIDTH > (1 << SX_W) || 32'(rsp_screen_x) < SCREEN_WIDTH)
            && (SCREEN_HEIGHT > (1 << SY_W) || 32'(rsp_screen_y) < SCREEN_HEIGHT))
      else $error("screen point beyond screen");

endmodule

bind touch_point_calibrated_mapper_unit tpcm_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tpcm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_touched  (rsp_touched),
   .rsp_screen_x (rsp_screen_x),
   .rsp_screen_y (rsp_screen_y),
   .rsp_raw_x    (rsp_raw_x),
   .rsp_raw_y    (rsp_raw_y)
);
